// ===== hw/rtl/homography_inlier_classifier_assert.svh =====
// assertion macros for the homography inlier classifier
`ifndef HOMOGRAPHY_INLIER_CLASSIFIER_ASSERT_SVH
`define HOMOGRAPHY_INLIER_CLASSIFIER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HIC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hic assertion failed");
`define HIC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hic assertion failed");
`else
`define HIC_ASSERT_IMP(lbl, ante, cons)
`define HIC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/hic_pkg.sv =====
// shared types and constants for the homography inlier classifier
package hic_pkg;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int COEF_W     = 48;
  localparam int IDX_W      = 10;
  localparam int SRC_W      = 16;
  localparam int PIX_FRAC   = 4;
  localparam int FRAC_W     = 36;
  localparam int LO_SPLIT   = 32;
  localparam int LO_W       = LO_SPLIT + SRC_W;
  localparam int HI_W       = (COEF_W - LO_SPLIT) + SRC_W + 1;
  localparam int TERM_W     = COEF_W + SRC_W + 1;
  localparam int SUM_W      = TERM_W + 2;
  localparam int MAG_W      = SUM_W - 1;
  localparam int QBITS      = 31;
  localparam int QUOT_W     = QBITS + 1;
  localparam int WIDE_W     = MAG_W + QBITS;
  localparam int DIFF_W     = QUOT_W + PIX_FRAC + 1;
  localparam int NEAR_W     = 20;
  localparam int SQ_W       = 2 * NEAR_W;
  localparam int SSQ_W      = SQ_W + 1;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  localparam int DEF_DIST_THRESHOLD = 4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_bank_t [NUM_REGS];

  localparam coef_t GAIN_ONE = coef_t'(1) <<< LO_SPLIT;
  localparam logic signed [SUM_W-1:0] DEN_ONE = SUM_W'(1) <<< FRAC_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_XX = 3'd0,
    REG_GAIN_XY = 3'd1,
    REG_SHIFT_X = 3'd2,
    REG_GAIN_YX = 3'd3,
    REG_GAIN_YY = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_PERSP_X = 3'd6,
    REG_PERSP_Y = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_OUTLIER = 2'd0,
    VERDICT_INLIER  = 2'd1,
    VERDICT_SKIP    = 2'd2,
    VERDICT_FAULT   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [SRC_W-1:0] obs_x;
    logic [SRC_W-1:0] obs_y;
    logic             skip;
    logic             fault;
  } tag_t;

endpackage

// ===== hw/rtl/homography_inlier_classifier.sv =====
// homography inlier classifier top level
// Scores one point correspondence per clock: the source point is mapped
// through the configured homography (ninth coefficient fixed at one), the
// projection is truncated to whole pixels and compared with the observed
// point against a squared distance threshold. Most of the pipeline is the
// divider, which resolves one quotient bit per pipeline stage over 31 stages
// for both coordinates at once. Throughput is one item per cycle whenever
// the result side takes items; a stall on out_tready freezes the whole
// pipeline. Coefficients may only be rewritten while no item is in flight.
module homography_inlier_classifier import hic_pkg::*; #(
  parameter int DIST_THRESHOLD = DEF_DIST_THRESHOLD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pair_index, src_x, src_y, obs_x, obs_y, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // excluded
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // result_index, verdict, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_wdata
);

  coef_bank_t                coef_r;
  logic                      adv;
  logic [IDX_W-1:0]          pair_index;
  logic [SRC_W-1:0]          src_x, src_y, obs_x, obs_y;
  tag_t                      in_tag;
  logic                      p_valid, d_valid, s_valid;
  logic signed [SUM_W-1:0]   num_x, num_y, den;
  tag_t                      p_tag, d_tag;
  logic signed [QUOT_W-1:0]  quot_x, quot_y;
  logic [IDX_W-1:0]          result_index;
  verdict_t                  verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= (i == int'(REG_GAIN_XX) || i == int'(REG_GAIN_YY)) ? GAIN_ONE : '0;
      end
    end else if (cfg_we) begin
      coef_r[cfg_index] <= $signed(cfg_wdata);
    end
  end

  assign adv       = !s_valid || out_tready;
  assign in_tready = adv;

  assign pair_index = in_tdata[IDX_W-1:0];
  assign src_x      = in_tdata[IDX_W +: SRC_W];
  assign src_y      = in_tdata[IDX_W + SRC_W +: SRC_W];
  assign obs_x      = in_tdata[IDX_W + 2*SRC_W +: SRC_W];
  assign obs_y      = in_tdata[IDX_W + 3*SRC_W +: SRC_W];

  always_comb begin
    in_tag.index = pair_index;
    in_tag.obs_x = obs_x;
    in_tag.obs_y = obs_y;
    // missing observation marked by a zero coordinate
    in_tag.skip  = in_tuser | (obs_x == '0) | (obs_y == '0);
    in_tag.fault = 1'b0;
  end

  hic_project u_project (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .src_x    (src_x),
    .src_y    (src_y),
    .in_tag   (in_tag),
    .coef     (coef_r),
    .out_valid(p_valid),
    .num_x    (num_x),
    .num_y    (num_y),
    .den      (den),
    .out_tag  (p_tag)
  );

  hic_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (p_valid),
    .num_x    (num_x),
    .num_y    (num_y),
    .den      (den),
    .in_tag   (p_tag),
    .out_valid(d_valid),
    .quot_x   (quot_x),
    .quot_y   (quot_y),
    .out_tag  (d_tag)
  );

  hic_score #(
    .DIST_THRESHOLD(DIST_THRESHOLD)
  ) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (d_valid),
    .quot_x     (quot_x),
    .quot_y     (quot_y),
    .in_tag     (d_tag),
    .out_valid  (s_valid),
    .out_index  (result_index),
    .out_verdict(verdict)
  );

  assign out_tvalid = s_valid;
  assign out_tdata  = {(OUT_DATA_W - IDX_W - 2)'(0), verdict, result_index};

endmodule

// ===== hw/rtl/hic_project.sv =====
// projection sums: numerators and denominator of the homography map
module hic_project import hic_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [SRC_W-1:0]        src_x,
  input  logic [SRC_W-1:0]        src_y,
  input  tag_t                    in_tag,
  input  coef_bank_t              coef,
  output logic                    out_valid,
  output logic signed [SUM_W-1:0] num_x,
  output logic signed [SUM_W-1:0] num_y,
  output logic signed [SUM_W-1:0] den,
  output tag_t                    out_tag
);

  localparam int NT = 6;

  coef_t                    c_sel  [NT];
  logic [SRC_W-1:0]         s_sel  [NT];
  logic [LO_W-1:0]          lo_nxt [NT];
  logic signed [HI_W-1:0]   hi_nxt [NT];
  logic [LO_W-1:0]          lo_r   [NT];
  logic signed [HI_W-1:0]   hi_r   [NT];
  logic signed [TERM_W-1:0] term_r [NT];
  logic signed [SUM_W-1:0]  nx_r, ny_r, den_r;
  logic                     v1_r, v2_r, v3_r;
  tag_t                     tag1_r, tag2_r, tag3_r;

  always_comb begin
    c_sel[0] = coef[REG_GAIN_XX]; s_sel[0] = src_x;
    c_sel[1] = coef[REG_GAIN_XY]; s_sel[1] = src_y;
    c_sel[2] = coef[REG_GAIN_YX]; s_sel[2] = src_x;
    c_sel[3] = coef[REG_GAIN_YY]; s_sel[3] = src_y;
    c_sel[4] = coef[REG_PERSP_X]; s_sel[4] = src_x;
    c_sel[5] = coef[REG_PERSP_Y]; s_sel[5] = src_y;
    for (int k = 0; k < NT; k++) begin
      lo_nxt[k] = LO_W'(c_sel[k][LO_SPLIT-1:0]) * LO_W'(s_sel[k]);
      hi_nxt[k] = HI_W'($signed(c_sel[k][COEF_W-1:LO_SPLIT]))
                  * HI_W'($signed({1'b0, s_sel[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NT; k++) begin
        lo_r[k]   <= lo_nxt[k];
        hi_r[k]   <= hi_nxt[k];
        term_r[k] <= (TERM_W'(hi_r[k]) <<< LO_SPLIT) + $signed(TERM_W'(lo_r[k]));
      end
      nx_r   <= SUM_W'(term_r[0]) + SUM_W'(term_r[1])
                + (SUM_W'(coef[REG_SHIFT_X]) <<< PIX_FRAC);
      ny_r   <= SUM_W'(term_r[2]) + SUM_W'(term_r[3])
                + (SUM_W'(coef[REG_SHIFT_Y]) <<< PIX_FRAC);
      den_r  <= SUM_W'(term_r[4]) + SUM_W'(term_r[5]) + DEN_ONE;
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  assign out_valid = v3_r;
  assign num_x     = nx_r;
  assign num_y     = ny_r;
  assign den       = den_r;
  assign out_tag   = tag3_r;

endmodule

// ===== hw/rtl/hic_divider.sv =====
// two-lane restoring divider, one quotient bit per stage
`include "homography_inlier_classifier_assert.svh"

module hic_divider import hic_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [SUM_W-1:0]  num_x,
  input  logic signed [SUM_W-1:0]  num_y,
  input  logic signed [SUM_W-1:0]  den,
  input  tag_t                     in_tag,
  output logic                     out_valid,
  output logic signed [QUOT_W-1:0] quot_x,
  output logic signed [QUOT_W-1:0] quot_y,
  output tag_t                     out_tag
);

  logic [MAG_W-1:0] anx_nxt, any_nxt, ad_nxt;
  logic [MAG_W-1:0] anx_r, any_r, ad_r;
  logic             anegx_r, anegy_r, av_r;
  tag_t             atag_nxt, atag_r;
  tag_t             btag_nxt;
  logic             ovf_x, ovf_y;

  logic [MAG_W-1:0] rx_r   [QBITS+1];
  logic [MAG_W-1:0] ry_r   [QBITS+1];
  logic [MAG_W-1:0] d_r    [QBITS+1];
  logic [QBITS-1:0] qx_r   [QBITS+1];
  logic [QBITS-1:0] qy_r   [QBITS+1];
  logic             negx_r [QBITS+1];
  logic             negy_r [QBITS+1];
  logic             v_r    [QBITS+1];
  tag_t             tag_r  [QBITS+1];

  // magnitudes, result signs and zero-denominator fault
  always_comb begin
    anx_nxt = num_x[SUM_W-1] ? MAG_W'(-num_x) : MAG_W'(num_x);
    any_nxt = num_y[SUM_W-1] ? MAG_W'(-num_y) : MAG_W'(num_y);
    ad_nxt  = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
    atag_nxt = in_tag;
    atag_nxt.fault = in_tag.fault | (den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
    end else if (adv) begin
      av_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      anx_r   <= anx_nxt;
      any_r   <= any_nxt;
      ad_r    <= ad_nxt;
      anegx_r <= num_x[SUM_W-1] ^ den[SUM_W-1];
      anegy_r <= num_y[SUM_W-1] ^ den[SUM_W-1];
      atag_r  <= atag_nxt;
    end
  end

  // quotient too large for 31 bits
  always_comb begin
    ovf_x = WIDE_W'(anx_r) >= (WIDE_W'(ad_r) << QBITS);
    ovf_y = WIDE_W'(any_r) >= (WIDE_W'(ad_r) << QBITS);
    btag_nxt = atag_r;
    btag_nxt.fault = atag_r.fault | ovf_x | ovf_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= av_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r[0]   <= anx_r;
      ry_r[0]   <= any_r;
      d_r[0]    <= ad_r;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      negx_r[0] <= anegx_r;
      negy_r[0] <= anegy_r;
      tag_r[0]  <= btag_nxt;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    localparam int BIT = QBITS - 1 - k;
    logic [WIDE_W-1:0] dsh;
    logic              ge_x, ge_y;

    assign dsh  = WIDE_W'(d_r[k]) << BIT;
    assign ge_x = WIDE_W'(rx_r[k]) >= dsh;
    assign ge_y = WIDE_W'(ry_r[k]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rx_r[k+1]   <= ge_x ? MAG_W'(WIDE_W'(rx_r[k]) - dsh) : rx_r[k];
        ry_r[k+1]   <= ge_y ? MAG_W'(WIDE_W'(ry_r[k]) - dsh) : ry_r[k];
        qx_r[k+1]   <= qx_r[k] | (QBITS'(ge_x) << BIT);
        qy_r[k+1]   <= qy_r[k] | (QBITS'(ge_y) << BIT);
        d_r[k+1]    <= d_r[k];
        negx_r[k+1] <= negx_r[k];
        negy_r[k+1] <= negy_r[k];
        tag_r[k+1]  <= tag_r[k];
      end
    end
  end

  assign quot_x    = negx_r[QBITS] ? -$signed({1'b0, qx_r[QBITS]})
                                   : $signed({1'b0, qx_r[QBITS]});
  assign quot_y    = negy_r[QBITS] ? -$signed({1'b0, qy_r[QBITS]})
                                   : $signed({1'b0, qy_r[QBITS]});
  assign out_valid = v_r[QBITS];
  assign out_tag   = tag_r[QBITS];

  `HIC_ASSERT_IMP(a_zero_den_faults, v_r[0] && (d_r[0] == '0), tag_r[0].fault)
  `HIC_ASSERT_IMP(a_rem_below_den, v_r[QBITS] && !tag_r[QBITS].fault,
                  (rx_r[QBITS] < d_r[QBITS]) && (ry_r[QBITS] < d_r[QBITS]))
  `HIC_ASSERT_NXT(a_hold_on_stall, !adv && v_r[QBITS],
                  $stable(qx_r[QBITS]) && $stable(qy_r[QBITS]))

endmodule

// ===== hw/rtl/hic_score.sv =====
// distance to the observed point and verdict
`include "homography_inlier_classifier_assert.svh"

module hic_score import hic_pkg::*; #(
  parameter int DIST_THRESHOLD = DEF_DIST_THRESHOLD
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [QUOT_W-1:0] quot_x,
  input  logic signed [QUOT_W-1:0] quot_y,
  input  tag_t                     in_tag,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_index,
  output verdict_t                 out_verdict
);

  localparam logic [SSQ_W-1:0] DIST_LIMIT =
    SSQ_W'(DIST_THRESHOLD * DIST_THRESHOLD * 256);

  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [DIFF_W-2:0]        adx_nxt, ady_nxt;
  logic [NEAR_W-1:0]        adx_r, ady_r;
  logic                     far2_r, far3_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic                     s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  tag_t                     tag1_r, tag2_r, tag3_r;
  logic [IDX_W-1:0]         index_r;
  verdict_t                 verdict_r, verdict_nxt;
  logic [SSQ_W-1:0]         ssq;

  always_comb begin
    adx_nxt = dx_r[DIFF_W-1] ? (DIFF_W-1)'(-dx_r) : dx_r[DIFF_W-2:0];
    ady_nxt = dy_r[DIFF_W-1] ? (DIFF_W-1)'(-dy_r) : dy_r[DIFF_W-2:0];
    ssq     = SSQ_W'(sqx_r) + SSQ_W'(sqy_r);
    if (tag3_r.skip) begin
      verdict_nxt = VERDICT_SKIP;
    end else if (tag3_r.fault) begin
      verdict_nxt = VERDICT_FAULT;
    end else if (far3_r || (ssq >= DIST_LIMIT)) begin
      verdict_nxt = VERDICT_OUTLIER;
    end else begin
      verdict_nxt = VERDICT_INLIER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r      <= (DIFF_W'(quot_x) <<< PIX_FRAC) - $signed(DIFF_W'(in_tag.obs_x));
      dy_r      <= (DIFF_W'(quot_y) <<< PIX_FRAC) - $signed(DIFF_W'(in_tag.obs_y));
      adx_r     <= adx_nxt[NEAR_W-1:0];
      ady_r     <= ady_nxt[NEAR_W-1:0];
      far2_r    <= (|adx_nxt[DIFF_W-2:NEAR_W]) | (|ady_nxt[DIFF_W-2:NEAR_W]);
      sqx_r     <= SQ_W'(adx_r) * SQ_W'(adx_r);
      sqy_r     <= SQ_W'(ady_r) * SQ_W'(ady_r);
      far3_r    <= far2_r;
      tag1_r    <= in_tag;
      tag2_r    <= tag1_r;
      tag3_r    <= tag2_r;
      index_r   <= tag3_r.index;
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_index   = index_r;
  assign out_verdict = verdict_r;

  `HIC_ASSERT_NXT(a_drain_to_out, adv && s3_valid_r, out_valid_r)

endmodule
